// ===== rtl/quoted_printable_encoder_defines.svh =====
// Assertion helpers shared by the encoder RTL.
`ifndef QUOTED_PRINTABLE_ENCODER_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define QPE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/qpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qpe_pkg;

	localparam int unsigned COL_W          = 7;
	localparam int unsigned STEP_W         = 3;
	localparam int unsigned QPE_FIFO_DEPTH = 4;

	localparam logic [COL_W-1:0] LIMIT_RESET = 7'd70;

	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam logic [0:0] REG_LINE_LIMIT = 1'b0;

	typedef struct packed {
		logic [7:0] data;
		logic       esc;
		logic       brk;
	} qpe_cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h37 + {4'd0, nib};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/qpe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_printable_encoder_defines.svh"
module qpe_front import qpe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [COL_W-1:0] limit,
	input  wire logic             push,
	input  wire logic [7:0]       in_byte,
	output qpe_cmd_t              cmd
);

	logic [COL_W-1:0] column_q;
	logic [COL_W:0]   col_next;
	logic             esc;
	logic             brk;
	logic             is_nl;

	always_comb begin
		is_nl = (in_byte == CH_NL);
		esc = in_byte[7]
			|| (column_q == '0 && in_byte == CH_DOT)
			|| (in_byte < CH_SP && in_byte != CH_TAB && !is_nl)
			|| in_byte == CH_EQ || in_byte == CH_DEL;
		if (esc) begin
			col_next = {1'b0, column_q} + 8'd3;
		end else if (in_byte == CH_TAB) begin
			col_next = {({1'b0, column_q[COL_W-1:3]} + 5'd1), 3'b000};
		end else begin
			col_next = {1'b0, column_q} + 8'd1;
		end
		brk = !is_nl && (col_next > {1'b0, limit});
		cmd.data = in_byte;
		cmd.esc  = esc;
		cmd.brk  = brk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (push) begin
			if (is_nl || brk) begin
				column_q <= '0;
			end else begin
				column_q <= col_next[COL_W-1:0];
			end
		end
	end

	`QPE_ASSERT_NEXT(a_col_in_limit, clk, arst_n, push, column_q <= $past(limit), "column above limit")

endmodule
`default_nettype wire

// ===== rtl/qpe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_printable_encoder_defines.svh"
module qpe_fifo import qpe_pkg::*; #(
	parameter int unsigned DEPTH = QPE_FIFO_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire qpe_cmd_t wr_cmd,
	output logic          full,
	input  wire logic     pop,
	output logic          head_valid,
	output qpe_cmd_t      head
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	qpe_cmd_t       mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`QPE_ASSERT_IMPL(a_no_overflow, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "queue overflow")
	`QPE_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, head_valid, "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/qpe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_printable_encoder_defines.svh"
module qpe_back import qpe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire qpe_cmd_t    head,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] out_byte
	output logic             m_tlast
);

	logic [STEP_W-1:0] step_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic [STEP_W-1:0] base;
	logic [STEP_W-1:0] total;
	logic [7:0]        byte_sel;
	logic              is_last;
	logic              adv;

	always_comb begin
		base  = head.esc ? STEP_W'(3) : STEP_W'(1);
		total = head.brk ? base + STEP_W'(2) : base;
		if (step_q < base) begin
			if (!head.esc) begin
				byte_sel = head.data;
			end else if (step_q == '0) begin
				byte_sel = CH_EQ;
			end else if (step_q == STEP_W'(1)) begin
				byte_sel = hex_char(head.data[7:4]);
			end else begin
				byte_sel = hex_char(head.data[3:0]);
			end
		end else if (step_q == base) begin
			byte_sel = CH_EQ;
		end else begin
			byte_sel = CH_NL;
		end
		is_last = (step_q == total - STEP_W'(1));
		adv     = head_valid && (!valid_q || m_tready);
		pop     = adv && is_last;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= byte_sel;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
			step_q  <= is_last ? '0 : step_q + 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

	`QPE_ASSERT_IMPL(a_step_range, clk, arst_n, 1'b1, step_q <= STEP_W'(4), "step out of range")

endmodule
`default_nettype wire

// ===== rtl/quoted_printable_encoder.sv =====
// Quoted-printable encoder.
// Input stream (s_*): one raw byte per item in s_tdata[7:0].
// Output stream (m_*): one encoded ASCII byte per item in m_tdata[7:0]; m_tlast
// marks the final output byte caused by an input byte.
// Each input byte yields 1 to 5 output bytes: the byte itself or '=' plus two
// hex digits, then '=' newline when the column passes line_limit.
// line_limit is set over the APB port at address 0 (7 bits, reset 70); write it
// only while the encoder is idle.
// An accepted input byte is written into the command queue, and its first
// output byte is then registered in the output register, which emits one
// byte per cycle while a command waits and the receiver is ready. The front end
// classifies one byte per cycle into a command queue of FIFO_DEPTH entries
// and keeps taking input until that queue fills.
// A stalled receiver holds the output register; the back end then stops
// draining the queue and s_tready drops once the queue is full.
// Reset clears the column, the queue and the output valid, and loads the
// limit with 70.
`timescale 1ns / 1ps
`default_nettype none
module quoted_printable_encoder import qpe_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = QPE_FIFO_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [COL_W-1:0] limit_q;
	logic             reg_hit;
	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;
	qpe_cmd_t         cmd;
	qpe_cmd_t         head;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_LINE_LIMIT);
	assign prdata  = reg_hit ? {{(32-COL_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			limit_q <= pwdata[COL_W-1:0];
		end
	end

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	qpe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (limit_q),
		.push    (push),
		.in_byte (s_tdata),
		.cmd     (cmd)
	);

	qpe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_cmd     (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	qpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire
